// ----- design/pculo_pkg.sv -----
// ----------------------------------------------------------------------------
// pculo_pkg
// shared types and constants of the pcm unpack / left justify / oversample unit
// ----------------------------------------------------------------------------
package pculo_pkg;

   // frame and repeat limits
   localparam int MAX_CHANNELS   = 8;
   localparam int MAX_OVERSAMPLE = 8;

   // field and register widths
   localparam int SAMPLE_BYTES_W = 2;
   localparam int FACTOR_W       = 4;
   localparam int COUNT_W        = 4;
   localparam int CHANNEL_W      = 3;
   localparam int REPEAT_W       = $clog2(MAX_OVERSAMPLE) < 1 ? 1 : $clog2(MAX_OVERSAMPLE);
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_BYTES      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERSAMPLE_FACTOR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT     = 2'd2;

   // register reset values
   localparam logic [SAMPLE_BYTES_W-1:0] SAMPLE_BYTES_RESET = 2'd3;
   localparam logic [FACTOR_W-1:0]       FACTOR_RESET       = 4'd1;
   localparam logic [COUNT_W-1:0]        COUNT_RESET        = 4'd2;

   // bytes per sample code for 24-bit input
   localparam logic [SAMPLE_BYTES_W-1:0] SAMPLE_BYTES_24 = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0]     sample_word;
      logic [CHANNEL_W-1:0]   channel_index;
      logic                   last;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_direct;
      logic start_emit;
      logic emit_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sample_done;
      logic os_one;
      logic frame_done;
      logic emit_last;
      logic out_free;
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

endpackage

// ----- design/pculo_ctrl.sv -----
// ----------------------------------------------------------------------------
// pculo_ctrl
// sequencer: takes bytes, then walks the stored frame for oversampled output
// ----------------------------------------------------------------------------
module pculo_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pculo_pkg::status_type status,
   output pculo_pkg::cmd_type    cmd
);

   pculo_pkg::state_type state_ff;
   pculo_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pculo_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      req_ready         = 1'b0;
      cmd.accept        = 1'b0;
      cmd.load_direct   = 1'b0;
      cmd.start_emit    = 1'b0;
      cmd.emit_step     = 1'b0;
      case (state_ff)
         pculo_pkg::ST_IDLE: begin
            // a byte that completes a sample at factor one needs the output slot
            req_ready  = !(status.sample_done && status.os_one) || status.out_free;
            cmd.accept = req_valid && req_ready;
            if (cmd.accept && status.sample_done) begin
               if (status.os_one) begin
                  cmd.load_direct = 1'b1;
               end else if (status.frame_done) begin
                  cmd.start_emit = 1'b1;
                  state_in       = pculo_pkg::ST_EMIT;
               end
            end
         end
         pculo_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_step = 1'b1;
               if (status.emit_last) begin
                  state_in = pculo_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = pculo_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/pculo_datapath.sv -----
// ----------------------------------------------------------------------------
// pculo_datapath
// byte assembly, frame store, repeat counters, registers and output word
// ----------------------------------------------------------------------------
module pculo_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pculo_pkg::req_payload_type             req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pculo_pkg::rsp_payload_type             rsp_payload,
   input  logic                                   csr_write_enable,
   input  logic [pculo_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pculo_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  pculo_pkg::cmd_type                     cmd,
   output pculo_pkg::status_type                  status
);

   // configuration registers
   logic [pculo_pkg::SAMPLE_BYTES_W-1:0] sample_bytes_ff;
   logic [pculo_pkg::FACTOR_W-1:0]       factor_ff;
   logic [pculo_pkg::COUNT_W-1:0]        count_ff;

   // assembly state
   logic [15:0]                     partial_ff,  partial_in;
   logic [1:0]                      byte_pos_ff, byte_pos_in;
   logic [pculo_pkg::CHANNEL_W-1:0] chan_pos_ff, chan_pos_in;

   // emission counters
   logic [pculo_pkg::CHANNEL_W-1:0] emit_ch_ff,  emit_ch_in;
   logic [pculo_pkg::REPEAT_W-1:0]  emit_rep_ff, emit_rep_in;

   logic [31:0] frame_store [pculo_pkg::MAX_CHANNELS];

   logic                        rsp_valid_ff, rsp_valid_in;
   pculo_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic                           is_24bit;
   logic [pculo_pkg::FACTOR_W-1:0] factor_eff;
   logic [pculo_pkg::COUNT_W-1:0]  count_eff;
   logic [31:0]                    word;
   logic                           ch_wrap;

   always_comb begin
      is_24bit = sample_bytes_ff == pculo_pkg::SAMPLE_BYTES_24;

      if (factor_ff == '0) begin
         factor_eff = pculo_pkg::FACTOR_W'(1);
      end else if (factor_ff > pculo_pkg::FACTOR_W'(pculo_pkg::MAX_OVERSAMPLE)) begin
         factor_eff = pculo_pkg::FACTOR_W'(pculo_pkg::MAX_OVERSAMPLE);
      end else begin
         factor_eff = factor_ff;
      end

      if (count_ff == '0) begin
         count_eff = pculo_pkg::COUNT_W'(1);
      end else if (count_ff > pculo_pkg::COUNT_W'(pculo_pkg::MAX_CHANNELS)) begin
         count_eff = pculo_pkg::COUNT_W'(pculo_pkg::MAX_CHANNELS);
      end else begin
         count_eff = count_ff;
      end

      // left justify: newest byte on top, gathered bytes below, zeros at the bottom
      if (is_24bit) begin
         word = {req_payload.data_byte, partial_ff, 8'h00};
      end else begin
         word = {req_payload.data_byte, partial_ff[7:0], 16'h0000};
      end

      status.sample_done = is_24bit ? (byte_pos_ff >= 2'd2) : (byte_pos_ff >= 2'd1);
      status.os_one      = factor_eff == pculo_pkg::FACTOR_W'(1);
      status.frame_done  = (pculo_pkg::COUNT_W'(chan_pos_ff) + pculo_pkg::COUNT_W'(1))
                           >= count_eff;
      ch_wrap            = pculo_pkg::COUNT_W'(emit_ch_ff) == count_eff - pculo_pkg::COUNT_W'(1);
      status.emit_last   = ch_wrap && (pculo_pkg::FACTOR_W'(emit_rep_ff)
                           == factor_eff - pculo_pkg::FACTOR_W'(1));
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      partial_in     = partial_ff;
      byte_pos_in    = byte_pos_ff;
      chan_pos_in    = chan_pos_ff;
      emit_ch_in     = emit_ch_ff;
      emit_rep_in    = emit_rep_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      if (cmd.accept) begin
         if (!status.sample_done) begin
            partial_in  = partial_ff | ({8'h00, req_payload.data_byte} << {byte_pos_ff[0], 3'b000});
            byte_pos_in = byte_pos_ff + 2'd1;
         end else begin
            partial_in  = '0;
            byte_pos_in = '0;
            chan_pos_in = status.frame_done ? '0 : chan_pos_ff + pculo_pkg::CHANNEL_W'(1);
         end
         if (req_payload.block_end) begin
            partial_in  = '0;
            byte_pos_in = '0;
            chan_pos_in = '0;
         end
      end

      if (cmd.load_direct) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in.sample_word = word;
         rsp_payload_in.channel_index = chan_pos_ff;
         rsp_payload_in.last        = 1'b1;
      end

      if (cmd.start_emit) begin
         emit_ch_in  = '0;
         emit_rep_in = '0;
      end

      // sample word of a burst step is read from the frame store in the clocked block
      if (cmd.emit_step) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.channel_index = emit_ch_ff;
         rsp_payload_in.last          = status.emit_last;
         if (ch_wrap) begin
            emit_ch_in  = '0;
            emit_rep_in = emit_rep_ff + pculo_pkg::REPEAT_W'(1);
         end else begin
            emit_ch_in  = emit_ch_ff + pculo_pkg::CHANNEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bytes_ff <= pculo_pkg::SAMPLE_BYTES_RESET;
         factor_ff       <= pculo_pkg::FACTOR_RESET;
         count_ff        <= pculo_pkg::COUNT_RESET;
         partial_ff      <= '0;
         byte_pos_ff     <= '0;
         chan_pos_ff     <= '0;
         emit_ch_ff      <= '0;
         emit_rep_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               pculo_pkg::CSR_SAMPLE_BYTES: begin
                  sample_bytes_ff <= csr_write_data[pculo_pkg::SAMPLE_BYTES_W-1:0];
               end
               pculo_pkg::CSR_OVERSAMPLE_FACTOR: begin
                  factor_ff <= csr_write_data[pculo_pkg::FACTOR_W-1:0];
               end
               pculo_pkg::CSR_CHANNEL_COUNT: begin
                  count_ff <= csr_write_data[pculo_pkg::COUNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         partial_ff   <= partial_in;
         byte_pos_ff  <= byte_pos_in;
         chan_pos_ff  <= chan_pos_in;
         emit_ch_ff   <= emit_ch_in;
         emit_rep_ff  <= emit_rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         rsp_payload_ff.sample_word <= frame_store[emit_ch_ff];
      end else begin
         rsp_payload_ff.sample_word <= rsp_payload_in.sample_word;
      end
      rsp_payload_ff.channel_index <= rsp_payload_in.channel_index;
      rsp_payload_ff.last          <= rsp_payload_in.last;
      if (cmd.accept && status.sample_done) begin
         frame_store[chan_pos_ff] <= word;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a new word never lands on top of one still waiting
   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |-> status.out_free)
      else $error("emit step while output word pending");

   a_direct_free : assert property (@(posedge clock) disable iff (reset)
      cmd.load_direct |-> status.out_free)
      else $error("direct load while output word pending");

   // after the final word of a burst the channel walk is back at zero
   a_burst_wrap : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_step && status.emit_last) |=> (emit_ch_ff == '0 && rsp_payload_ff.last))
      else $error("burst end did not wrap channel counter");

   // an accepted byte with block end leaves no partial sample or frame behind
   a_block_end : assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_payload.block_end) |=>
         (byte_pos_ff == '0 && chan_pos_ff == '0 && partial_ff == '0))
      else $error("block end left partial state");

endmodule

// ----- design/pcm_unpack_left_justify_oversample_unit.sv -----
// ----------------------------------------------------------------------------
// pcm_unpack_left_justify_oversample_unit
// pcm byte stream to left-justified 32-bit samples with zero-order-hold repeat
// ----------------------------------------------------------------------------
// usage
//  - req channel carries one raw pcm word a transfer: a byte plus block end flag
//  - rsp channel carries one sample word a transfer with its channel and last flag
//  - csr port: write enable, index, data; user writes only while the unit is idle, not enforced
//  - a byte that only gathers, or completes a sample at factor one, is taken
//    with no burst; a completed sample leaves via the output register next cycle
//  - at factor above one, the byte closing a frame starts a burst of
//    factor x channels words from the frame store, one per cycle while the output
//    slot is free; no byte is taken during the burst
//  - the output register sets the pace: one word per cycle at most
//  - a stalled receiver holds the output word; bytes that produce no word are
//    still taken; at factor one a byte that would produce one waits for a free slot
//  - synchronous reset clears counters, gathered bytes and the output valid, and
//    restores 24-bit samples, factor one, two channels; the frame store keeps
//    whatever it held and entries count only once written
// ----------------------------------------------------------------------------
module pcm_unpack_left_justify_oversample_unit (
   input  logic                              clock,
   input  logic                              reset,
   // byte input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pculo_pkg::req_payload_type        req_payload,
   // sample output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pculo_pkg::rsp_payload_type        rsp_payload,
   // register writes
   input  logic                              csr_write_enable,
   input  logic [pculo_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pculo_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   // command and status between sequencer and datapath
   pculo_pkg::cmd_type    cmd;
   pculo_pkg::status_type status;

   // sequencer: byte intake and burst walk
   pculo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: assembly, frame store, output register, csr
   pculo_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ----- test/pcm_unpack_left_justify_oversample_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pcm_unpack_left_justify_oversample_unit_tb
// self-checking bench: pcm bytes in, left-justified sample words out
// ----------------------------------------------------------------------------
// a queue of pending pcm bytes feeds a clocked driver; a clocked monitor keeps
// its own copy of the unpack state and registers, works out the sample words
// each accepted byte must produce and checks every output word against the
// oldest one waiting. directed bytes cover the corner cases, then random
// buffers of whole and broken frames run under many register settings, with
// bursty idling on both sides and one long receiver stall
// ----------------------------------------------------------------------------
module pcm_unpack_left_justify_oversample_unit_tb;

   localparam int RANDOM_ITEMS     = 280;
   localparam int CALM_ITEMS       = 40;
   localparam int SETTLE_CYCLES    = 10;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 3000;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   pculo_pkg::req_payload_type        req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   pculo_pkg::rsp_payload_type        rsp_payload;
   logic                              csr_write_enable = 1'b0;
   logic [pculo_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pculo_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   pcm_unpack_left_justify_oversample_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // pcm words waiting to be offered, and sample words still owed by the unit
   pculo_pkg::req_payload_type byte_queue[$];
   pculo_pkg::rsp_payload_type expected_samples[$];

   // knobs set by the stimulus process at the falling edge
   bit calm = 1'b0;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   bit long_hold_request = 1'b0;

   int mismatch_count = 0;

   // mirror of the unit's registers and unpack state
   logic [pculo_pkg::SAMPLE_BYTES_W-1:0] cfg_sample_bytes;
   logic [pculo_pkg::FACTOR_W-1:0]       cfg_factor;
   logic [pculo_pkg::COUNT_W-1:0]        cfg_channels;
   logic [15:0]                          gathered;
   logic [1:0]                           gathered_count;
   logic [31:0]                          held_frame [pculo_pkg::MAX_CHANNELS];
   logic [pculo_pkg::CHANNEL_W-1:0]      next_channel;
   pculo_pkg::rsp_payload_type           oldest_sample;

   // ---------------------------------------------------------------------------
   // sample prediction
   // ---------------------------------------------------------------------------
   task automatic post_sample(input logic [31:0] word, input int ch, input logic is_last);
      pculo_pkg::rsp_payload_type s;
      s.sample_word   = word;
      s.channel_index = ch[pculo_pkg::CHANNEL_W-1:0];
      s.last          = is_last;
      expected_samples.push_back(s);
   endtask

   task automatic unpack_byte(input pculo_pkg::req_payload_type w);
      int          size;
      int          reps;
      int          chans;
      int          cp;
      int          pos;
      logic [31:0] merged;
      logic [31:0] keep;
      logic [31:0] word;
      // out-of-range register values clamp to the nearest legal setting
      size  = (cfg_sample_bytes < 2) ? 2 : int'(cfg_sample_bytes);
      reps  = (cfg_factor == 0) ? 1 :
              (cfg_factor > pculo_pkg::MAX_OVERSAMPLE) ? pculo_pkg::MAX_OVERSAMPLE :
              int'(cfg_factor);
      chans = (cfg_channels == 0) ? 1 :
              (cfg_channels > pculo_pkg::MAX_CHANNELS) ? pculo_pkg::MAX_CHANNELS :
              int'(cfg_channels);
      pos   = gathered_count;
      if (pos + 1 < size) begin
         // still gathering: little endian, byte n lands at bit 8n
         merged = {24'd0, w.data_byte} << (8 * pos);
         gathered = gathered | merged[15:0];
         gathered_count = gathered_count + 2'd1;
      end else begin
         // a shrunken size keeps only the low size-1 gathered bytes
         keep = (size == 2) ? 32'h0000_00ff : 32'h0000_ffff;
         word = {w.data_byte, 24'd0} | (({16'd0, gathered} & keep) << (32 - 8 * size));
         cp = next_channel;
         held_frame[cp] = word;
         gathered = '0;
         gathered_count = '0;
         if (reps == 1) begin
            post_sample(word, cp, 1'b1);
            next_channel = (cp + 1 >= chans) ? '0 : pculo_pkg::CHANNEL_W'(cp + 1);
         end else if (cp + 1 >= chans) begin
            // frame closed: zero-order hold, whole frame repeated in channel order
            for (int r = 0; r < reps; r++)
               for (int c = 0; c < chans; c++)
                  post_sample(held_frame[c], c, (r == reps - 1) && (c == chans - 1));
            next_channel = '0;
         end else begin
            next_channel = pculo_pkg::CHANNEL_W'(cp + 1);
         end
      end
      // block end drops whatever partial sample or frame is left
      if (w.block_end) begin
         gathered = '0;
         gathered_count = '0;
         next_channel = '0;
      end
   endtask

   // ---------------------------------------------------------------------------
   // driver: one pcm word at a time, held until taken, bursty gaps
   // ---------------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (send_idle_on && !calm && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            send_gap <= $urandom_range(0, 15);
         end else if (byte_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_payload <= byte_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: bursty ready, plus one long hold so the unit backs up
   // ---------------------------------------------------------------------------
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  hold_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
         hold_left <= 0;
      end else if (long_hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (recv_idle_on && !calm && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         recv_gap <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: check output words, predict from accepted bytes, track registers
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         cfg_sample_bytes <= pculo_pkg::SAMPLE_BYTES_RESET;
         cfg_factor <= pculo_pkg::FACTOR_RESET;
         cfg_channels <= pculo_pkg::COUNT_RESET;
         gathered <= '0;
         gathered_count <= '0;
         next_channel <= '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected sample word: expected none, got %h ch %0d last %b",
                        $time, rsp_payload.sample_word, rsp_payload.channel_index,
                        rsp_payload.last);
            end else begin
               oldest_sample = expected_samples.pop_front();
               if (rsp_payload.sample_word !== oldest_sample.sample_word ||
                   rsp_payload.channel_index !== oldest_sample.channel_index ||
                   rsp_payload.last !== oldest_sample.last) begin
                  mismatch_count++;
                  $display({"%0t sample mismatch: expected %h ch %0d last %b,",
                            " got %h ch %0d last %b"},
                           $time, oldest_sample.sample_word, oldest_sample.channel_index,
                           oldest_sample.last, rsp_payload.sample_word,
                           rsp_payload.channel_index, rsp_payload.last);
               end
            end
         end
         if (req_valid && req_ready)
            unpack_byte(req_payload);
         if (csr_write_enable) begin
            case (csr_index)
               pculo_pkg::CSR_SAMPLE_BYTES: begin
                  cfg_sample_bytes = csr_write_data[pculo_pkg::SAMPLE_BYTES_W-1:0];
               end
               pculo_pkg::CSR_OVERSAMPLE_FACTOR: begin
                  cfg_factor = csr_write_data[pculo_pkg::FACTOR_W-1:0];
               end
               pculo_pkg::CSR_CHANNEL_COUNT: begin
                  cfg_channels = csr_write_data[pculo_pkg::COUNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long with no word moving on either side
   // ---------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pcm_unpack_left_justify_oversample_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] data, input logic blk_end);
      pculo_pkg::req_payload_type w;
      w.data_byte = data;
      w.block_end = blk_end;
      byte_queue.push_back(w);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic write_csr(input logic [pculo_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [pculo_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input int sb, input int os, input int ch);
      write_csr(pculo_pkg::CSR_SAMPLE_BYTES, pculo_pkg::CSR_DATA_W'(sb));
      write_csr(pculo_pkg::CSR_OVERSAMPLE_FACTOR, pculo_pkg::CSR_DATA_W'(os));
      write_csr(pculo_pkg::CSR_CHANNEL_COUNT, pculo_pkg::CSR_DATA_W'(ch));
   endtask

   // all bytes taken and every owed word out, then room for a gathering byte
   task automatic wait_drained;
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // one buffer of whole frames closed by block end; some cut short or left open
   task automatic queue_buffer(input int sb, input int ch, inout int count);
      int   size;
      int   chans;
      int   len;
      bit   closes;
      logic [7:0] data;
      size   = (sb < 2) ? 2 : sb;
      chans  = (ch == 0) ? 1 : (ch > pculo_pkg::MAX_CHANNELS) ? pculo_pkg::MAX_CHANNELS : ch;
      len    = $urandom_range(1, 3) * size * chans;
      closes = ($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 4) == 0)
         len = $urandom_range(1, len);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0: data = 8'h00;
            1: data = 8'hff;
            2: data = 8'h80;
            3: data = 8'h7f;
            default: data = 8'($urandom_range(0, 255));
         endcase
         queue_byte(data, closes && (i == len - 1));
         count++;
      end
   endtask

   initial begin
      int random_items;
      int calm_items;
      int sb;
      int os;
      int ch;
      int phase;
      random_items = 0;
      calm_items = 0;
      phase = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, 24-bit two channels: full-scale words, block end mid-frame,
      // then two bytes left gathered
      queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h80, 1'b0);
      queue_byte(8'hff, 1'b0); queue_byte(8'hff, 1'b0); queue_byte(8'h7f, 1'b0);
      queue_byte(8'h11, 1'b0); queue_byte(8'h22, 1'b0); queue_byte(8'h33, 1'b1);
      queue_byte(8'h44, 1'b0); queue_byte(8'h55, 1'b0);
      wait_drained;

      // sample size dropped to 16-bit with two bytes already gathered
      write_csr(pculo_pkg::CSR_SAMPLE_BYTES, pculo_pkg::CSR_DATA_W'(2));
      queue_byte(8'h66, 1'b0);
      queue_byte(8'h01, 1'b1);
      wait_drained;

      // 16-bit, four channels, factor four: stop one sample short of the frame
      set_config(2, 4, 4);
      queue_byte(8'h00, 1'b0); queue_byte(8'h80, 1'b0);
      queue_byte(8'hff, 1'b0); queue_byte(8'h7f, 1'b0);
      queue_byte(8'h34, 1'b0); queue_byte(8'h12, 1'b0);
      wait_drained;

      // channel count dropped mid-frame: next sample closes the frame
      write_csr(pculo_pkg::CSR_CHANNEL_COUNT, pculo_pkg::CSR_DATA_W'(2));
      queue_byte(8'h78, 1'b0); queue_byte(8'h56, 1'b0);
      wait_drained;

      // out-of-range codes: size 1 acts as 2, factor 15 saturates, count 0 acts as 1
      set_config(1, 15, 0);
      queue_byte(8'h01, 1'b0); queue_byte(8'h80, 1'b1);
      wait_drained;

      // random buffers under changing settings
      while (random_items < RANDOM_ITEMS) begin
         if (phase == 0) begin
            // widest frame, longest repeat
            sb = 3; os = pculo_pkg::MAX_OVERSAMPLE; ch = pculo_pkg::MAX_CHANNELS;
         end else if (phase == 1) begin
            // one word per two bytes while the receiver holds off
            sb = 2; os = 1; ch = 1;
         end else begin
            case ($urandom_range(0, 5))
               4: sb = 2;
               5: sb = 3;
               default: sb = $urandom_range(0, 3);
            endcase
            case ($urandom_range(0, 5))
               0: os = 0;
               1: os = 1;
               2: os = pculo_pkg::MAX_OVERSAMPLE;
               3: os = 15;
               default: os = $urandom_range(0, 15);
            endcase
            case ($urandom_range(0, 5))
               0: ch = 0;
               1: ch = 1;
               2: ch = pculo_pkg::MAX_CHANNELS;
               3: ch = 15;
               default: ch = $urandom_range(0, 15);
            endcase
         end
         set_config(sb, os, ch);
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 1) begin
            repeat (10) queue_buffer(sb, ch, random_items);
            long_hold_request = 1'b1;
         end else begin
            repeat ($urandom_range(1, 3)) queue_buffer(sb, ch, random_items);
         end
         wait_drained;
         phase++;
      end

      // closing stretch with no idling on either side
      calm = 1'b1;
      set_config(3, $urandom_range(1, pculo_pkg::MAX_OVERSAMPLE),
                 $urandom_range(1, pculo_pkg::MAX_CHANNELS));
      while (calm_items < CALM_ITEMS)
         queue_buffer(3, int'(cfg_channels), calm_items);
      wait_drained;

      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("pcm_unpack_left_justify_oversample_unit verification clean");
      else
         $display("pcm_unpack_left_justify_oversample_unit verification failed");
      $finish;
   end

endmodule
